// File: design/hrsd_pkg.sv
// Shared constants and types of the HDR scanline decoder.
package hrsd_pkg;

   localparam int BYTE_W  = 8;
   localparam int FLOAT_W = 32;

   localparam logic [1:0] ST_PIXEL = 2'd0;
   localparam logic [1:0] ST_WIDTH = 2'd1;
   localparam logic [1:0] ST_COUNT = 2'd2;
   localparam logic [1:0] ST_BUSY  = 2'd3;

   localparam logic CSR_LINE_WIDTH = 1'b0;
   localparam logic CSR_LINE_COUNT = 1'b1;

   typedef enum logic [3:0] {
      SEQ_IDLE = 4'b0001,
      SEQ_FILL = 4'b0010,
      SEQ_READ = 4'b0100,
      SEQ_EMIT = 4'b1000
   } seq_type;

   typedef enum logic [7:0] {
      PH_HDR    = 8'b0000_0001,
      PH_FLAT   = 8'b0000_0010,
      PH_COUNT  = 8'b0000_0100,
      PH_RUNVAL = 8'b0000_1000,
      PH_LIT    = 8'b0001_0000,
      PH_DONE   = 8'b0010_0000,
      PH_ERRW   = 8'b0100_0000,
      PH_ERRC   = 8'b1000_0000
   } phase_type;

endpackage

// File: design/hrsd_ram.sv
// Generic single-port RAM with registered read.
module hrsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 12288
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/hrsd_cvt.sv
// Shared converter from one RGBE mantissa and exponent to IEEE single bits.
module hrsd_cvt (
   input  logic [hrsd_pkg::BYTE_W-1:0]  mant,
   input  logic [hrsd_pkg::BYTE_W-1:0]  expo,
   output logic [hrsd_pkg::FLOAT_W-1:0] bits
);

   logic [2:0]        msb;
   logic signed [9:0] be;
   logic [31:0]       wide;
   logic [31:0]       norm;
   logic [31:0]       sub;

   always_comb begin
      msb = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (mant[i]) begin
            msb = 3'(i);
         end
      end
   end

   assign be   = $signed({7'd0, msb}) + $signed({2'd0, expo}) - 10'sd9;
   assign wide = {24'd0, mant};
   assign norm = wide << (5'd23 - {2'd0, msb});
   assign sub  = wide << ({1'b0, expo[4:0]} + 6'd13);

   always_comb begin
      priority if (expo == '0 || mant == '0) begin
         bits = '0;
      end else if (be > 10'sd0) begin
         bits = {1'b0, be[7:0], norm[22:0]};
      end else begin
         bits = sub;
      end
   end

endmodule

// File: design/hdr_rle_scanline_decoder_top.sv
// Top level of the HDR RGBE pixel-stream decoder with its sequencer.
//
// Usage: stream pixel bytes of an RGBE image (header text removed) on req_.
// req_tuser is 0 for a data byte in req_tdata, 1 for a drain tick that pulls
// one pending pixel of an exponent run. Each decoded pixel leaves on rsp_ as
// three IEEE single words in rsp_tdata; rsp_tlast marks the last pixel of a
// scanline, rsp_tuser carries the status and the end-of-image flag. Errors
// leave as status words with zero data and stay until reset.
// A pixel is accepted, passes through the line store read port (RLE pixels
// only) and the single shared float converter in SEQ_READ, then goes into
// the output register in SEQ_EMIT. A run of channel bytes fills the store
// in SEQ_FILL, one store write per cycle. csr_ writes set line_width
// (index 0) and line_count (index 1) and take effect at once.
// Reset (synchronous) returns to expecting a scanline header and clears
// errors; the line store is not cleared. When rsp_tready is low the result
// waits in the output register; the next byte is still taken, and the
// decoder holds only when it has another word to deliver.
module hdr_rle_scanline_decoder_top #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // byte_value
   input  logic [0:0]   req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // red_bits, green_bits, blue_bits
   output logic         rsp_tlast,
   output logic [2:0]   rsp_tuser,   // status, image_end
   input  logic         csr_wr_en,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam int AW = $clog2(3 * MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH);
   localparam logic [WW-1:0] WRAP_LAST = WW'(MAX_WIDTH - 1);
   localparam logic [AW-1:0] BASE1 = AW'(MAX_WIDTH);
   localparam logic [AW-1:0] BASE2 = AW'(2 * MAX_WIDTH);

   hrsd_pkg::seq_type   seq_ff, seq_in;
   hrsd_pkg::phase_type phase_ff, phase_in;
   logic [12:0] lw_ff, lw_in;
   logic [15:0] lc_ff, lc_in;
   logic [12:0] col_ff, col_in;
   logic [WW-1:0] wrap_ff, wrap_in;
   logic [1:0]  ch_ff, ch_in;
   logic [15:0] rows_ff, rows_in;
   logic [7:0]  seg_ff, seg_in;
   logic [6:0]  runp_ff, runp_in;
   logic [31:0] grp_ff, grp_in;
   logic [1:0]  gidx_ff, gidx_in;
   logic [7:0]  exph_ff, exph_in;
   logic [7:0]  pexp_ff, pexp_in;
   logic        flat_ff, flat_in;
   logic [23:0] fb_ff, fb_in;
   logic [7:0]  fv_ff, fv_in;
   logic [1:0]  stat_ff, stat_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic        ov_ff, ov_in;
   logic [95:0] od_ff, od_in;
   logic [1:0]  ost_ff, ost_in;
   logic        ole_ff, ole_in, oie_ff, oie_in;

   logic        accept;
   logic        ram_we;
   logic [1:0]  ram_ch;
   logic [AW-1:0] ram_addr;
   logic [AW-1:0] base;
   logic [7:0]  ram_wdata, ram_rdata;
   logic [7:0]  cvt_mant;
   logic [31:0] cvt_bits;
   logic [31:0] gb;
   logic [12:0] rem;
   logic [7:0]  cnt_n;
   logic [12:0] col_n;
   logic [WW-1:0] wrap_n;
   logic [15:0] rows_n;
   logic [7:0]  seg_n;
   logic        out_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (seq_ff == hrsd_pkg::SEQ_IDLE);
   assign out_free   = !ov_ff || rsp_tready;
   assign col_n      = col_ff + 13'd1;
   assign wrap_n     = (wrap_ff == WRAP_LAST) ? '0 : wrap_ff + 1'b1;
   assign rows_n     = rows_ff + 16'd1;
   assign rem        = (col_ff < lw_ff) ? lw_ff - col_ff : 13'd0;
   assign gb         = grp_ff | ({24'd0, req_tdata} << {gidx_ff, 3'b000});
   assign seg_n      = (seg_ff != 8'd0) ? seg_ff - 8'd1 : seg_ff;
   assign cnt_n      = (req_tdata > 8'd128) ? req_tdata - 8'd128 : req_tdata;

   assign ram_ch = (seq_ff == hrsd_pkg::SEQ_READ) ? cnt_ff : ch_ff;
   always_comb begin
      unique case (ram_ch)
         2'd1:    base = BASE1;
         2'd2:    base = BASE2;
         default: base = '0;
      endcase
   end
   assign ram_addr  = base + AW'(wrap_ff);
   assign ram_wdata = (seq_ff == hrsd_pkg::SEQ_FILL) ? fv_ff : req_tdata;
   assign ram_we    = (seq_ff == hrsd_pkg::SEQ_FILL)
                   || (accept && req_tuser[0] == 1'b0 && runp_ff == 7'd0
                       && phase_ff == hrsd_pkg::PH_LIT && ch_ff != 2'd3
                       && lw_ff != 13'd0 && lc_ff != 16'd0);

   hrsd_ram #(.WIDTH(8), .DEPTH(3 * MAX_WIDTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      unique case (cnt_ff)
         2'd1:    cvt_mant = flat_ff ? fb_ff[7:0]   : ram_rdata;
         2'd2:    cvt_mant = flat_ff ? fb_ff[15:8]  : ram_rdata;
         default: cvt_mant = flat_ff ? fb_ff[23:16] : ram_rdata;
      endcase
   end

   hrsd_cvt u_cvt (
      .mant (cvt_mant),
      .expo (pexp_ff),
      .bits (cvt_bits)
   );

   always_comb begin
      seq_in = seq_ff;   phase_in = phase_ff; lw_in = lw_ff;   lc_in = lc_ff;
      col_in = col_ff;   wrap_in = wrap_ff;   ch_in = ch_ff;   rows_in = rows_ff;
      seg_in = seg_ff;   runp_in = runp_ff;   grp_in = grp_ff; gidx_in = gidx_ff;
      exph_in = exph_ff; pexp_in = pexp_ff;   flat_in = flat_ff; fb_in = fb_ff;
      fv_in = fv_ff;     stat_in = stat_ff;   cnt_in = cnt_ff;
      red_in = red_ff;   green_in = green_ff; blue_in = blue_ff;
      ov_in = ov_ff && !rsp_tready;
      od_in = od_ff;     ost_in = ost_ff;     ole_in = ole_ff; oie_in = oie_ff;

      if (csr_wr_en) begin
         unique case (csr_index[0])
            hrsd_pkg::CSR_LINE_WIDTH: lw_in = csr_wdata[12:0];
            hrsd_pkg::CSR_LINE_COUNT: lc_in = csr_wdata;
         endcase
      end

      unique case (seq_ff)
         hrsd_pkg::SEQ_IDLE: begin
            if (accept) begin
               priority if (phase_ff == hrsd_pkg::PH_ERRW
                            || phase_ff == hrsd_pkg::PH_ERRC) begin
                  if (req_tuser[0] == 1'b0) begin
                     stat_in = (phase_ff == hrsd_pkg::PH_ERRW) ? hrsd_pkg::ST_WIDTH
                                                               : hrsd_pkg::ST_COUNT;
                     seq_in  = hrsd_pkg::SEQ_EMIT;
                  end
               end else if (req_tuser[0] == 1'b1) begin
                  if (runp_ff != 7'd0 && phase_ff != hrsd_pkg::PH_DONE) begin
                     runp_in = runp_ff - 7'd1;
                     pexp_in = exph_ff;
                     flat_in = 1'b0;
                     stat_in = hrsd_pkg::ST_PIXEL;
                     cnt_in  = 2'd0;
                     seq_in  = hrsd_pkg::SEQ_READ;
                  end
               end else if (runp_ff != 7'd0) begin
                  stat_in = hrsd_pkg::ST_BUSY;
                  seq_in  = hrsd_pkg::SEQ_EMIT;
               end else if (phase_ff == hrsd_pkg::PH_DONE || lw_ff == 13'd0
                            || lc_ff == 16'd0) begin
                  seq_in = hrsd_pkg::SEQ_IDLE;
               end else begin
                  unique case (phase_ff)
                     hrsd_pkg::PH_HDR, hrsd_pkg::PH_FLAT: begin
                        gidx_in = gidx_ff + 2'd1;
                        grp_in  = gb;
                        if (gidx_ff == 2'd3) begin
                           grp_in = '0;
                           if (phase_ff == hrsd_pkg::PH_HDR && lw_ff >= 13'd8
                               && gb[7:0] == 8'd2 && gb[15:8] == 8'd2 && !gb[23]) begin
                              if ({gb[22:16], gb[31:24]} != {2'b00, lw_ff}
                                  || 32'(lw_ff) > MAX_WIDTH) begin
                                 phase_in = hrsd_pkg::PH_ERRW;
                                 stat_in  = hrsd_pkg::ST_WIDTH;
                                 seq_in   = hrsd_pkg::SEQ_EMIT;
                              end else begin
                                 phase_in = hrsd_pkg::PH_COUNT;
                                 ch_in    = 2'd0;
                                 col_in   = '0;
                                 wrap_in  = '0;
                              end
                           end else begin
                              phase_in = hrsd_pkg::PH_FLAT;
                              fb_in    = gb[23:0];
                              pexp_in  = gb[31:24];
                              flat_in  = 1'b1;
                              stat_in  = hrsd_pkg::ST_PIXEL;
                              cnt_in   = 2'd0;
                              seq_in   = hrsd_pkg::SEQ_READ;
                           end
                        end
                     end
                     hrsd_pkg::PH_COUNT: begin
                        seg_in = cnt_n;
                        if (cnt_n == 8'd0 || {5'd0, cnt_n} > rem) begin
                           phase_in = hrsd_pkg::PH_ERRC;
                           stat_in  = hrsd_pkg::ST_COUNT;
                           seq_in   = hrsd_pkg::SEQ_EMIT;
                        end else begin
                           phase_in = (req_tdata > 8'd128) ? hrsd_pkg::PH_RUNVAL
                                                           : hrsd_pkg::PH_LIT;
                        end
                     end
                     hrsd_pkg::PH_RUNVAL: begin
                        phase_in = hrsd_pkg::PH_COUNT;
                        if (ch_ff != 2'd3) begin
                           fv_in  = req_tdata;
                           seq_in = hrsd_pkg::SEQ_FILL;
                        end else begin
                           seg_in  = 8'd0;
                           exph_in = req_tdata;
                           runp_in = seg_n[6:0];
                           pexp_in = req_tdata;
                           flat_in = 1'b0;
                           stat_in = hrsd_pkg::ST_PIXEL;
                           cnt_in  = 2'd0;
                           seq_in  = hrsd_pkg::SEQ_READ;
                        end
                     end
                     hrsd_pkg::PH_LIT: begin
                        seg_in = seg_n;
                        if (seg_n == 8'd0) begin
                           phase_in = hrsd_pkg::PH_COUNT;
                        end
                        if (ch_ff != 2'd3) begin
                           if (col_n >= lw_ff) begin
                              col_in  = '0;
                              wrap_in = '0;
                              ch_in   = ch_ff + 2'd1;
                           end else begin
                              col_in  = col_n;
                              wrap_in = wrap_n;
                           end
                        end else begin
                           pexp_in = req_tdata;
                           flat_in = 1'b0;
                           stat_in = hrsd_pkg::ST_PIXEL;
                           cnt_in  = 2'd0;
                           seq_in  = hrsd_pkg::SEQ_READ;
                        end
                     end
                     default: seq_in = hrsd_pkg::SEQ_IDLE;
                  endcase
               end
            end
         end
         hrsd_pkg::SEQ_FILL: begin
            seg_in = seg_n;
            if (seg_ff == 8'd1) begin
               seq_in = hrsd_pkg::SEQ_IDLE;
               if (col_n >= lw_ff) begin
                  col_in  = '0;
                  wrap_in = '0;
                  ch_in   = ch_ff + 2'd1;
               end else begin
                  col_in  = col_n;
                  wrap_in = wrap_n;
               end
            end else begin
               col_in  = col_n;
               wrap_in = wrap_n;
            end
         end
         hrsd_pkg::SEQ_READ: begin
            cnt_in = cnt_ff + 2'd1;
            unique case (cnt_ff)
               2'd1:    red_in   = cvt_bits;
               2'd2:    green_in = cvt_bits;
               2'd3:    blue_in  = cvt_bits;
               default: red_in   = red_ff;
            endcase
            if (cnt_ff == 2'd3) begin
               seq_in = hrsd_pkg::SEQ_EMIT;
            end
         end
         hrsd_pkg::SEQ_EMIT: begin
            if (out_free) begin
               ov_in  = 1'b1;
               ost_in = stat_ff;
               od_in  = '0;
               ole_in = 1'b0;
               oie_in = 1'b0;
               seq_in = hrsd_pkg::SEQ_IDLE;
               if (stat_ff == hrsd_pkg::ST_PIXEL) begin
                  od_in = {blue_ff, green_ff, red_ff};
                  if (col_n >= lw_ff) begin
                     ole_in  = 1'b1;
                     col_in  = '0;
                     wrap_in = '0;
                     ch_in   = 2'd0;
                     rows_in = rows_n;
                     if (rows_n >= lc_ff) begin
                        oie_in   = 1'b1;
                        phase_in = hrsd_pkg::PH_DONE;
                     end else if (phase_ff != hrsd_pkg::PH_FLAT) begin
                        phase_in = hrsd_pkg::PH_HDR;
                     end
                  end else begin
                     col_in  = col_n;
                     wrap_in = wrap_n;
                  end
               end
            end
         end
         default: seq_in = hrsd_pkg::SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= hrsd_pkg::SEQ_IDLE;
         phase_ff <= hrsd_pkg::PH_HDR;
         lw_ff    <= 13'd8;
         lc_ff    <= 16'd1;
         col_ff   <= '0;
         wrap_ff  <= '0;
         ch_ff    <= '0;
         rows_ff  <= '0;
         seg_ff   <= '0;
         runp_ff  <= '0;
         grp_ff   <= '0;
         gidx_ff  <= '0;
         exph_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         seq_ff   <= seq_in;
         phase_ff <= phase_in;
         lw_ff    <= lw_in;
         lc_ff    <= lc_in;
         col_ff   <= col_in;
         wrap_ff  <= wrap_in;
         ch_ff    <= ch_in;
         rows_ff  <= rows_in;
         seg_ff   <= seg_in;
         runp_ff  <= runp_in;
         grp_ff   <= grp_in;
         gidx_ff  <= gidx_in;
         exph_ff  <= exph_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      pexp_ff  <= pexp_in;
      flat_ff  <= flat_in;
      fb_ff    <= fb_in;
      fv_ff    <= fv_in;
      stat_ff  <= stat_in;
      cnt_ff   <= cnt_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      od_ff    <= od_in;
      ost_ff   <= ost_in;
      ole_ff   <= ole_in;
      oie_ff   <= oie_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tlast  = ole_ff;
   assign rsp_tuser  = {oie_ff, ost_ff};

`ifndef SYNTHESIS
   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      seq_ff == hrsd_pkg::SEQ_FILL |-> seg_ff != 8'd0)
      else $error("run fill with empty count");
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      ov_ff && ost_ff != hrsd_pkg::ST_PIXEL |-> od_ff == '0 && !ole_ff && !oie_ff)
      else $error("status word carries pixel data");
   a_image_line: assert property (@(posedge clock) disable iff (reset)
      ov_ff && oie_ff |-> ole_ff)
      else $error("image end without line end");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      seq_ff == hrsd_pkg::SEQ_READ && cnt_ff != 2'd3 |=> seq_ff == hrsd_pkg::SEQ_READ)
      else $error("read sequence cut short");
`endif

endmodule

// File: bench/tb_hdr_rle_scanline_decoder_top.sv
// Testbench of the HDR RGBE scanline decoder: streams RLE and flat scanlines and checks each word.
`timescale 1ns / 100ps

module tb_hdr_rle_scanline_decoder_top;

   localparam int STORE_W   = 4096;
   localparam int LIMIT     = 3000000;
   localparam int SETTLE    = 160;

   typedef struct {
      logic [31:0] red;
      logic [31:0] green;
      logic [31:0] blue;
      logic [1:0]  status;
      logic        line_end;
      logic        image_end;
   } pixel_word_type;

   class pixel_scoreboard_type;
      pixel_word_type      expected_q[$];
      int                  errors;
      int                  width_reg;
      int                  count_reg;
      logic [7:0]          line_store[3*STORE_W];
      hrsd_pkg::phase_type phase;
      int                  chan;
      int                  col;
      int                  rows_done;
      int                  seg_left;
      int                  run_left;
      logic [31:0]         group;
      int                  group_idx;
      logic [7:0]          exp_hold;
      bit                  err_flag;

      function new();
         errors = 0;
         width_reg = 8;
         count_reg = 1;
         phase = hrsd_pkg::PH_HDR;
         chan = 0;
         col = 0;
         rows_done = 0;
         seg_left = 0;
         run_left = 0;
         group = 0;
         group_idx = 0;
         exp_hold = 0;
         err_flag = 0;
      endfunction

      function void write_csr(logic idx, int value);
         if (idx == hrsd_pkg::CSR_LINE_WIDTH) width_reg = value & 16'h1fff;
         else count_reg = value & 16'hffff;
      endfunction

      function logic [31:0] to_float(logic [7:0] m, logic [7:0] e);
         int          p;
         int          be;
         logic [31:0] mm;
         logic [31:0] bee;
         if (e == 0 || m == 0) return 32'd0;
         mm = 32'(m);
         p = 7;
         while (!m[p]) p--;
         be = p + int'(e) - 9;
         if (be > 0) begin
            bee = be;
            return (bee << 23) | ((mm << (23 - p)) & 32'h7fffff);
         end
         return mm << (int'(e) + 13);
      endfunction

      function void push_status(logic [1:0] st);
         pixel_word_type w;
         w = '{32'd0, 32'd0, 32'd0, st, 1'b0, 1'b0};
         expected_q.push_back(w);
      endfunction

      function void push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] e);
         pixel_word_type w;
         w = '{to_float(r, e), to_float(g, e), to_float(b, e), hrsd_pkg::ST_PIXEL,
               1'b0, 1'b0};
         col = (col + 1) & 16'h1fff;
         if (col >= width_reg) begin
            w.line_end = 1'b1;
            col = 0;
            chan = 0;
            rows_done = (rows_done + 1) & 16'hffff;
            if (rows_done >= count_reg) begin
               w.image_end = 1'b1;
               phase = hrsd_pkg::PH_DONE;
            end else if (phase != hrsd_pkg::PH_FLAT) begin
               phase = hrsd_pkg::PH_HDR;
            end
         end
         expected_q.push_back(w);
      endfunction

      function void push_stored(logic [7:0] e);
         int c;
         c = col % STORE_W;
         push_pixel(line_store[c], line_store[STORE_W + c], line_store[2*STORE_W + c], e);
      endfunction

      function void flag_error(logic [1:0] st);
         err_flag = 1;
         phase = (st == hrsd_pkg::ST_WIDTH) ? hrsd_pkg::PH_ERRW : hrsd_pkg::PH_ERRC;
         push_status(st);
      endfunction

      function void next_channel();
         if (col >= width_reg) begin
            col = 0;
            chan = (chan + 1) & 3;
         end
      endfunction

      function void note_input(logic kind, logic [7:0] value);
         int         rem;
         int         n;
         logic [7:0] b0, b1, b2, b3;
         if (err_flag) begin
            if (kind) return;
            push_status((phase == hrsd_pkg::PH_ERRW) ? hrsd_pkg::ST_WIDTH
                                                     : hrsd_pkg::ST_COUNT);
            return;
         end
         if (kind) begin
            if (run_left == 0 || phase == hrsd_pkg::PH_DONE) return;
            run_left--;
            push_stored(exp_hold);
            return;
         end
         if (run_left > 0) begin
            push_status(hrsd_pkg::ST_BUSY);
            return;
         end
         if (phase == hrsd_pkg::PH_DONE || width_reg == 0 || count_reg == 0) return;
         rem = (col < width_reg) ? width_reg - col : 0;
         case (phase)
            hrsd_pkg::PH_HDR, hrsd_pkg::PH_FLAT: begin
               group = group | (32'(value) << (8 * (group_idx & 3)));
               group_idx++;
               if (group_idx < 4) return;
               {b3, b2, b1, b0} = group;
               group = 0;
               group_idx = 0;
               if (phase == hrsd_pkg::PH_HDR && width_reg >= 8 && b0 == 2 && b1 == 2
                   && !b2[7]) begin
                  if (((int'(b2) << 8) | int'(b3)) != width_reg || width_reg > STORE_W) begin
                     flag_error(hrsd_pkg::ST_WIDTH);
                     return;
                  end
                  phase = hrsd_pkg::PH_COUNT;
                  chan = 0;
                  col = 0;
                  return;
               end
               phase = hrsd_pkg::PH_FLAT;
               push_pixel(b0, b1, b2, b3);
            end
            hrsd_pkg::PH_COUNT: begin
               if (value > 128) begin
                  n = value - 128;
                  if (n > rem) begin
                     flag_error(hrsd_pkg::ST_COUNT);
                     return;
                  end
                  phase = hrsd_pkg::PH_RUNVAL;
               end else begin
                  n = value;
                  if (n == 0 || n > rem) begin
                     flag_error(hrsd_pkg::ST_COUNT);
                     return;
                  end
                  phase = hrsd_pkg::PH_LIT;
               end
               seg_left = n;
            end
            hrsd_pkg::PH_RUNVAL: begin
               n = seg_left;
               seg_left = 0;
               phase = hrsd_pkg::PH_COUNT;
               if (chan < 3) begin
                  for (int k = 0; k < n; k++)
                     line_store[(chan % 3) * STORE_W + ((col + k) % STORE_W)] = value;
                  col = (col + n) & 16'h1fff;
                  next_channel();
                  return;
               end
               exp_hold = value;
               run_left = (n > 0) ? ((n - 1) & 8'h7f) : 0;
               push_stored(value);
            end
            hrsd_pkg::PH_LIT: begin
               if (seg_left > 0) seg_left--;
               if (seg_left == 0) phase = hrsd_pkg::PH_COUNT;
               if (chan < 3) begin
                  line_store[(chan % 3) * STORE_W + (col % STORE_W)] = value;
                  col = (col + 1) & 16'h1fff;
                  next_channel();
                  return;
               end
               push_stored(value);
            end
            default: ;
         endcase
      endfunction

      function void check_word(logic [95:0] data, logic last, logic [2:0] user);
         pixel_word_type w;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected word data %h last %b user %h", $time, data, last, user);
            errors++;
            return;
         end
         w = expected_q.pop_front();
         if (data[31:0] !== w.red) begin
            $display("%0t: red expected %h actual %h", $time, w.red, data[31:0]);
            errors++;
         end
         if (data[63:32] !== w.green) begin
            $display("%0t: green expected %h actual %h", $time, w.green, data[63:32]);
            errors++;
         end
         if (data[95:64] !== w.blue) begin
            $display("%0t: blue expected %h actual %h", $time, w.blue, data[95:64]);
            errors++;
         end
         if (user[1:0] !== w.status) begin
            $display("%0t: status expected %h actual %h", $time, w.status, user[1:0]);
            errors++;
         end
         if (last !== w.line_end) begin
            $display("%0t: line_end expected %b actual %b", $time, w.line_end, last);
            errors++;
         end
         if (user[2] !== w.image_end) begin
            $display("%0t: image_end expected %b actual %b", $time, w.image_end, user[2]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // byte_value
   logic [0:0]  req_tuser = '0;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;        // red_bits, green_bits, blue_bits
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;        // status, image_end
   logic        csr_wr_en = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   pixel_scoreboard_type sb = new();
   int cycle_count = 0;
   int items_sent = 0;

   hdr_rle_scanline_decoder_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("tb_hdr_rle_scanline_decoder_top failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   // receiver: random holds, calm stretches, one long hold
   initial begin
      int hold;
      bit long_done;
      hold = 0;
      long_done = 0;
      forever begin
         @(negedge clock);
         if (!long_done && cycle_count > 4000) begin
            long_done = 1;
            hold = 500;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else if ((cycle_count / 700) % 3 == 2 || $urandom_range(0, 99) < 65) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
         end
      end
   end

   task automatic send_item(logic kind, logic [7:0] value);
      int r;
      r = $urandom_range(0, 99);
      if ((cycle_count / 900) % 3 != 1 && r >= 70) begin
         req_tvalid <= 1'b0;
         repeat ((r >= 96) ? $urandom_range(8, 35) : $urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      sb.note_input(kind, value);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, int value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.write_csr(idx, value);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_value(bit is_exp);
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd255;
      if (is_exp && r < 4) return 8'($urandom_range(1, 10));
      return 8'($urandom_range(0, 255));
   endfunction

   // mode: 0 random, 1 literals only, 2 runs only, 3 longest segments
   task automatic send_rle_line(int w, int mode, bit noise);
      int left;
      int n;
      bit run;
      send_item(1'b0, 8'd2);
      send_item(1'b0, 8'd2);
      send_item(1'b0, 8'(w >> 8));
      send_item(1'b0, 8'(w & 255));
      for (int ch = 0; ch < 4; ch++) begin
         left = w;
         while (left > 0) begin
            run = (mode == 2) || (mode != 1 && $urandom_range(0, 1));
            if (run) begin
               n = (mode == 3) ? ((left < 127) ? left : 127)
                               : $urandom_range(1, (left < 127) ? left : 127);
               send_item(1'b0, 8'(128 + n));
               send_item(1'b0, pick_value(ch == 3));
               if (ch == 3) begin
                  if (noise && n > 1 && $urandom_range(0, 3) == 0)
                     send_item(1'b0, 8'($urandom_range(0, 255)));
                  repeat (n - 1) send_item(1'b1, 8'($urandom_range(0, 255)));
                  if (noise && $urandom_range(0, 4) == 0) send_item(1'b1, 8'd0);
               end
            end else begin
               n = (mode == 3) ? ((left < 128) ? left : 128)
                               : $urandom_range(1, (left < 128) ? left : 128);
               send_item(1'b0, 8'(n));
               repeat (n) send_item(1'b0, pick_value(ch == 3));
            end
            left -= n;
         end
      end
   endtask

   task automatic send_flat_line(int w);
      repeat (w) begin
         send_item(1'b0, pick_value(0));
         send_item(1'b0, pick_value(0));
         send_item(1'b0, pick_value(0));
         send_item(1'b0, pick_value(1));
         if ($urandom_range(0, 9) == 0) send_item(1'b1, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int w;
      int end_mode;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_csr(hrsd_pkg::CSR_LINE_COUNT, 65535);
      send_rle_line(8, 1, 0);
      send_rle_line(8, 2, 1);
      write_csr(hrsd_pkg::CSR_LINE_WIDTH, 128);
      send_rle_line(128, 3, 0);

      w = 128;
      while (items_sent < 450) begin
         if ($urandom_range(0, 2) == 0) begin
            w = $urandom_range(8, 24);
            write_csr(hrsd_pkg::CSR_LINE_WIDTH, w);
         end
         send_rle_line(w, 0, 1);
      end
      write_csr(hrsd_pkg::CSR_LINE_WIDTH, 160);
      send_rle_line(160, 3, 1);
      w = $urandom_range(8, 20);
      write_csr(hrsd_pkg::CSR_LINE_WIDTH, w);
      send_rle_line(w, 0, 1);

      end_mode = $urandom_range(0, 3);
      if (end_mode == 0) begin
         send_item(1'b0, 8'd2);
         send_item(1'b0, 8'd2);
         send_item(1'b0, 8'd0);
         send_item(1'b0, 8'(w + 1));
      end else if (end_mode == 1) begin
         send_item(1'b0, 8'd2);
         send_item(1'b0, 8'd2);
         send_item(1'b0, 8'd0);
         send_item(1'b0, 8'(w));
         send_item(1'b0, ($urandom_range(0, 1)) ? 8'd0 : 8'(128 + w + 1));
      end
      if (end_mode < 2) begin
         repeat (20) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
         write_csr(hrsd_pkg::CSR_LINE_WIDTH, 1);
         send_item(1'b0, 8'd2);
         send_item(1'b0, 8'd2);
         send_item(1'b0, 8'd0);
         send_item(1'b0, 8'd1);
         while (items_sent < 1000) begin
            if ($urandom_range(0, 2) == 0)
               write_csr(hrsd_pkg::CSR_LINE_WIDTH, $urandom_range(1, 12));
            send_flat_line(sb.width_reg);
         end
         write_csr(hrsd_pkg::CSR_LINE_COUNT, sb.rows_done + 1);
         send_flat_line(sb.width_reg);
         repeat (10) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end

      wait_idle();
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("tb_hdr_rle_scanline_decoder_top passed");
      end else begin
         $display("tb_hdr_rle_scanline_decoder_top failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/hrsd_pkg.sv
design/hrsd_ram.sv
design/hrsd_cvt.sv
design/hdr_rle_scanline_decoder_top.sv
bench/tb_hdr_rle_scanline_decoder_top.sv
